// ----- design/cordic_sc_pkg.sv -----
// Package for the CORDIC sine and cosine core.
// Holds the word widths, the turn constants and the arctangent step table.
// Used by the channel interfaces and by cordic_sine_cosine_core.
package cordic_sc_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned Iterations = 31;

  typedef logic        [DataW-1:0] angle_t;
  typedef logic signed [DataW-1:0] sample_t;

  // Start vector x: the inverse CORDIC gain, negative, y starts at zero.
  localparam sample_t StartX        = 32'shb2458939;
  localparam angle_t  QuarterTurn   = 32'h3fffffff;
  localparam angle_t  ThreeQuarters = 32'hbffffffd;

  // atan(2^-i) scaled so that 2^32 is one full turn.
  localparam angle_t AngleSteps [32] = '{
    32'h1fffffff, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
    32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
    32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
    32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
    32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
    32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000a, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

endpackage

// ----- design/cordic_sc_phase_if.sv -----
// Phase channel of the CORDIC sine and cosine core: valid, ready and one
// unsigned phase word. Depends on cordic_sc_pkg.
interface cordic_sc_phase_if
  import cordic_sc_pkg::*;
;
  logic   valid;
  logic   ready;
  angle_t phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

// ----- design/cordic_sc_result_if.sv -----
// Result channel of the CORDIC sine and cosine core: valid, ready and the
// signed sine and cosine words. Depends on cordic_sc_pkg.
interface cordic_sc_result_if
  import cordic_sc_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sine_value;
  sample_t cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

// ----- design/cordic_sine_cosine_core.sv -----
// Pipelined CORDIC core: each accepted phase word (one full turn spans the
// 32-bit range) gives one word with its sine and cosine in signed s0.31.
// One phase is taken every clock while the pipeline is not stalled; it has
// one register stage for the quadrant fold and one for each micro-rotation.
// Every stage holds its own valid bit, so a stall on the result side fills
// bubbles first and only then holds the input ready low. Results next to
// plus or minus one may wrap, as in the fixed-point algorithm. Depends on
// cordic_sc_pkg and the channel interfaces.
module cordic_sine_cosine_core
  import cordic_sc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cordic_sc_phase_if.sink           phase_i,
  cordic_sc_result_if.source        result_o
);

  localparam int unsigned LastStage = Iterations;

  // Stage 0 holds the folded start vector; stage k holds the vector after
  // rotation k-1.
  logic    [LastStage:0]   valid_q;
  logic    [LastStage+1:0] stage_ready;
  sample_t x_q [LastStage+1];
  sample_t y_q [LastStage+1];
  angle_t  z_q [LastStage+1];

  sample_t fold_x_d;
  angle_t  fold_z_d;

  assign stage_ready[LastStage+1] = result_o.ready;

  // Quadrant fold of the incoming phase.
  always_comb begin
    if (phase_i.phase < QuarterTurn) begin
      fold_x_d = -StartX;
      fold_z_d = phase_i.phase + QuarterTurn;
    end else if (phase_i.phase < ThreeQuarters) begin
      fold_x_d = StartX;
      fold_z_d = phase_i.phase - QuarterTurn;
    end else begin
      fold_x_d = -StartX;
      fold_z_d = phase_i.phase - ThreeQuarters;
    end
  end

  assign stage_ready[0] = !valid_q[0] || stage_ready[1];
  assign phase_i.ready  = stage_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (stage_ready[0]) begin
      valid_q[0] <= phase_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[0] && phase_i.valid) begin
      x_q[0] <= fold_x_d;
      y_q[0] <= '0;
      z_q[0] <= fold_z_d;
    end
  end

  for (genvar k = 1; k <= LastStage; k++) begin : g_rot
    sample_t x_d;
    sample_t y_d;
    angle_t  z_d;
    sample_t x_shift;
    sample_t y_shift;

    assign stage_ready[k] = !valid_q[k] || stage_ready[k+1];

    // Rotation k-1 shifts by a fixed amount, so the shifters are wiring.
    assign x_shift = x_q[k-1] >>> (k - 1);
    assign y_shift = y_q[k-1] >>> (k - 1);

    always_comb begin
      if (z_q[k-1] >= QuarterTurn) begin
        x_d = x_q[k-1] - y_shift;
        y_d = y_q[k-1] + x_shift;
        z_d = z_q[k-1] - AngleSteps[k-1];
      end else begin
        x_d = x_q[k-1] + y_shift;
        y_d = y_q[k-1] - x_shift;
        z_d = z_q[k-1] + AngleSteps[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[k] && valid_q[k-1]) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
      end
    end
  end

  assign result_o.valid        = valid_q[LastStage];
  assign result_o.sine_value   = y_q[LastStage];
  assign result_o.cosine_value = x_q[LastStage];

  // The residual angle of the last stage is not needed at the output.
  logic unused_angle;
  assign unused_angle = ^z_q[LastStage];

endmodule
